// ----- src/cih_pkg.sv -----
package cih_pkg;

  localparam logic [3:0] KIND_UINT      = 4'd0;
  localparam logic [3:0] KIND_INT       = 4'd1;
  localparam logic [3:0] KIND_BSTR      = 4'd2;
  localparam logic [3:0] KIND_TSTR      = 4'd3;
  localparam logic [3:0] KIND_ARRAY     = 4'd4;
  localparam logic [3:0] KIND_MAP       = 4'd5;
  localparam logic [3:0] KIND_BOOL      = 4'd6;
  localparam logic [3:0] KIND_NULL      = 4'd7;
  localparam logic [3:0] KIND_ARR_INDEF = 4'd8;
  localparam logic [3:0] KIND_MAP_INDEF = 4'd9;
  localparam logic [3:0] KIND_BREAK     = 4'd10;
  localparam logic [3:0] KIND_FLOAT     = 4'd11;

  // major types, already shifted into the top three bits
  localparam logic [7:0] MT_UINT = 8'h00;
  localparam logic [7:0] MT_NINT = 8'h20;
  localparam logic [7:0] MT_BSTR = 8'h40;
  localparam logic [7:0] MT_TSTR = 8'h60;
  localparam logic [7:0] MT_ARR  = 8'h80;
  localparam logic [7:0] MT_MAP  = 8'hA0;
  localparam logic [7:0] MT_SMPL = 8'hE0;

  localparam logic [4:0] AI_INLINE_MAX = 5'd23;
  localparam logic [4:0] AI_ONE        = 5'd24;
  localparam logic [4:0] AI_TWO        = 5'd25;
  localparam logic [4:0] AI_FOUR       = 5'd26;
  localparam logic [4:0] AI_INDEF      = 5'd31;
  localparam logic [4:0] AI_FALSE      = 5'd20;
  localparam logic [4:0] AI_NULL       = 5'd22;

  localparam logic [7:0] SINGLE_BIAS = 8'd127;
  localparam logic [7:0] HALF_BIAS   = 8'd15;

  // head classes handed from decode to pack
  localparam logic [1:0] CLS_HEAD = 2'd0;
  localparam logic [1:0] CLS_ONE  = 2'd1;
  localparam logic [1:0] CLS_FLT2 = 2'd2;
  localparam logic [1:0] CLS_FLT4 = 2'd3;

  localparam int MAX_BYTES = 5;

  typedef struct packed {
    logic [3:0]  kind;
    logic [31:0] value;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last;
  } out_item_t;

  typedef struct packed {
    logic [1:0]  cls;
    logic [7:0]  ib;
    logic [31:0] arg;
  } dec_t;

  typedef struct packed {
    logic [MAX_BYTES-1:0][7:0] bytes;
    logic [2:0]                cnt;
  } pack_t;

endpackage

// ----- src/cih_decode.sv -----
module cih_decode (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              hf_en,
  input  logic              in_valid,
  output logic              in_stall,
  input  cih_pkg::in_item_t in_data,
  output logic              dec_valid,
  input  logic              dec_ready,
  output cih_pkg::dec_t     dec_data
);
  import cih_pkg::*;

  logic       valid_r, valid_nxt;
  dec_t       data_r, data_nxt;
  logic       ready;
  logic       kind_ok;
  logic [7:0] fexp;
  logic [7:0] hexp;
  logic       half_ok;
  logic [4:0] he;

  assign ready    = !valid_r || dec_ready;
  assign in_stall = !ready;

  assign fexp = in_data.value[30:23];
  assign hexp = fexp + HALF_BIAS - SINGLE_BIAS;
  assign half_ok = hf_en && (in_data.value[12:0] == 13'd0) &&
                   ((fexp >= SINGLE_BIAS - 8'd14 && fexp <= SINGLE_BIAS + HALF_BIAS) ||
                    fexp == 8'hFF || fexp == 8'h00);
  // zero and all-ones exponents map straight through
  assign he = (fexp == 8'hFF || fexp == 8'h00) ? fexp[4:0] : hexp[4:0];

  always_comb begin
    kind_ok       = 1'b1;
    data_nxt.cls  = CLS_HEAD;
    data_nxt.ib   = MT_UINT;
    data_nxt.arg  = in_data.value;
    case (in_data.kind)
      KIND_UINT: data_nxt.ib = MT_UINT;
      KIND_INT: begin
        if (in_data.value[31]) begin
          data_nxt.ib  = MT_NINT;
          data_nxt.arg = ~in_data.value;
        end
      end
      KIND_BSTR:  data_nxt.ib = MT_BSTR;
      KIND_TSTR:  data_nxt.ib = MT_TSTR;
      KIND_ARRAY: data_nxt.ib = MT_ARR;
      KIND_MAP:   data_nxt.ib = MT_MAP;
      KIND_BOOL: begin
        data_nxt.cls = CLS_ONE;
        data_nxt.ib  = MT_SMPL | {3'd0, AI_FALSE + {4'd0, in_data.value[0]}};
      end
      KIND_NULL: begin
        data_nxt.cls = CLS_ONE;
        data_nxt.ib  = MT_SMPL | {3'd0, AI_NULL};
      end
      KIND_ARR_INDEF: begin
        data_nxt.cls = CLS_ONE;
        data_nxt.ib  = MT_ARR | {3'd0, AI_INDEF};
      end
      KIND_MAP_INDEF: begin
        data_nxt.cls = CLS_ONE;
        data_nxt.ib  = MT_MAP | {3'd0, AI_INDEF};
      end
      KIND_BREAK: begin
        data_nxt.cls = CLS_ONE;
        data_nxt.ib  = MT_SMPL | {3'd0, AI_INDEF};
      end
      KIND_FLOAT: begin
        data_nxt.ib = MT_SMPL;
        if (half_ok) begin
          data_nxt.cls = CLS_FLT2;
          data_nxt.arg = {16'd0, in_data.value[31], he, in_data.value[22:13]};
        end else begin
          data_nxt.cls = CLS_FLT4;
        end
      end
      default: kind_ok = 1'b0;
    endcase
  end

  // undefined kinds are taken and dropped here
  always_comb begin
    valid_nxt = valid_r;
    if (ready) valid_nxt = in_valid && kind_ok;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ready && in_valid) data_r <= data_nxt;
  end

  assign dec_valid = valid_r;
  assign dec_data  = data_r;

endmodule

// ----- src/cih_pack.sv -----
module cih_pack (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           dec_valid,
  output logic           dec_ready,
  input  cih_pkg::dec_t  dec_data,
  output logic           pk_valid,
  input  logic           pk_ready,
  output cih_pkg::pack_t pk_data
);
  import cih_pkg::*;

  logic        valid_r, valid_nxt;
  pack_t       data_r, data_nxt;
  logic [31:0] a;

  assign dec_ready = !valid_r || pk_ready;
  assign a = dec_data.arg;

  always_comb begin
    data_nxt.bytes = '0;
    data_nxt.cnt   = 3'd1;
    case (dec_data.cls)
      CLS_HEAD: begin
        if (a <= {27'd0, AI_INLINE_MAX}) begin
          data_nxt.bytes[0] = dec_data.ib | {3'd0, a[4:0]};
        end else if (a[31:8] == 24'd0) begin
          data_nxt.bytes[0] = dec_data.ib | {3'd0, AI_ONE};
          data_nxt.bytes[1] = a[7:0];
          data_nxt.cnt      = 3'd2;
        end else if (a[31:16] == 16'd0) begin
          data_nxt.bytes[0] = dec_data.ib | {3'd0, AI_TWO};
          data_nxt.bytes[1] = a[15:8];
          data_nxt.bytes[2] = a[7:0];
          data_nxt.cnt      = 3'd3;
        end else begin
          data_nxt.bytes[0] = dec_data.ib | {3'd0, AI_FOUR};
          data_nxt.bytes[1] = a[31:24];
          data_nxt.bytes[2] = a[23:16];
          data_nxt.bytes[3] = a[15:8];
          data_nxt.bytes[4] = a[7:0];
          data_nxt.cnt      = 3'd5;
        end
      end
      CLS_ONE: data_nxt.bytes[0] = dec_data.ib;
      CLS_FLT2: begin
        data_nxt.bytes[0] = dec_data.ib | {3'd0, AI_TWO};
        data_nxt.bytes[1] = a[15:8];
        data_nxt.bytes[2] = a[7:0];
        data_nxt.cnt      = 3'd3;
      end
      default: begin
        data_nxt.bytes[0] = dec_data.ib | {3'd0, AI_FOUR};
        data_nxt.bytes[1] = a[31:24];
        data_nxt.bytes[2] = a[23:16];
        data_nxt.bytes[3] = a[15:8];
        data_nxt.bytes[4] = a[7:0];
        data_nxt.cnt      = 3'd5;
      end
    endcase
  end

  always_comb begin
    valid_nxt = valid_r;
    if (dec_ready) valid_nxt = dec_valid;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (dec_ready && dec_valid) data_r <= data_nxt;
  end

  assign pk_valid = valid_r;
  assign pk_data  = data_r;

endmodule

// ----- src/cih_serial.sv -----
module cih_serial (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               pk_valid,
  output logic               pk_ready,
  input  cih_pkg::pack_t     pk_data,
  output logic               out_valid,
  input  logic               out_stall,
  output cih_pkg::out_item_t out_data
);
  import cih_pkg::*;

  logic                      valid_r, valid_nxt;
  logic [2:0]                cnt_r, cnt_nxt;
  logic [MAX_BYTES-1:0][7:0] bytes_r, bytes_nxt;
  logic                      fire;
  logic                      done;

  assign fire     = valid_r && !out_stall;
  assign done     = fire && (cnt_r == 3'd1);
  // next item loads in the same cycle its predecessor's last byte leaves
  assign pk_ready = !valid_r || done;

  always_comb begin
    valid_nxt = valid_r;
    cnt_nxt   = cnt_r;
    bytes_nxt = bytes_r;
    if (pk_ready) begin
      valid_nxt = pk_valid;
      cnt_nxt   = pk_data.cnt;
      bytes_nxt = pk_data.bytes;
    end else if (fire) begin
      cnt_nxt   = cnt_r - 3'd1;
      bytes_nxt = bytes_r >> 8;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      cnt_r   <= 3'd0;
    end else begin
      valid_r <= valid_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    bytes_r <= bytes_nxt;
  end

  assign out_valid         = valid_r;
  assign out_data.out_byte = bytes_r[0];
  assign out_data.last     = (cnt_r == 3'd1);

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r |-> (cnt_r != 3'd0 && cnt_r <= 3'(MAX_BYTES)))
    else $error("byte count out of range");

  a_no_gap: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && cnt_r != 3'd1) |=> valid_r)
    else $error("gap inside an item's head");

  a_count_down: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && cnt_r != 3'd1) |=> (cnt_r == $past(cnt_r) - 3'd1))
    else $error("byte count did not step down");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (valid_r && out_stall) |=> (cnt_r == $past(cnt_r)))
    else $error("count moved while stalled");

endmodule

// ----- src/cbor_item_head_encoder_unit.sv -----
// CBOR data item head encoder. Each input transaction (kind, value) yields the
// head bytes of one item, one output transaction per byte, most significant
// first, with last set on the final byte; undefined kinds 12 to 15 are taken
// and give no output. Three register stages (decode, byte packing, output
// serializer) lie between the input and the first output byte. An input can
// be taken every cycle while in_stall is low; a head of n bytes (1, 2, 3 or 5)
// holds the serializer until its last byte has left, so longer heads and
// out_stall hold the input back through in_stall. cfg_we writes
// half_float_enable from cfg_wdata; write it only while the pipeline is empty.
module cbor_item_head_encoder_unit (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  cih_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output cih_pkg::out_item_t out_data,
  input  logic               cfg_we,
  input  logic               cfg_wdata
);
  import cih_pkg::*;

  logic  hf_en_r, hf_en_nxt;
  logic  dec_valid, dec_ready;
  dec_t  dec_data;
  logic  pk_valid, pk_ready;
  pack_t pk_data;

  assign hf_en_nxt = cfg_we ? cfg_wdata : hf_en_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hf_en_r <= 1'b0;
    end else begin
      hf_en_r <= hf_en_nxt;
    end
  end

  cih_decode u_decode (
    .clk       (clk),
    .rst_n     (rst_n),
    .hf_en     (hf_en_r),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .dec_valid (dec_valid),
    .dec_ready (dec_ready),
    .dec_data  (dec_data)
  );

  cih_pack u_pack (
    .clk       (clk),
    .rst_n     (rst_n),
    .dec_valid (dec_valid),
    .dec_ready (dec_ready),
    .dec_data  (dec_data),
    .pk_valid  (pk_valid),
    .pk_ready  (pk_ready),
    .pk_data   (pk_data)
  );

  cih_serial u_serial (
    .clk       (clk),
    .rst_n     (rst_n),
    .pk_valid  (pk_valid),
    .pk_ready  (pk_ready),
    .pk_data   (pk_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
